### rtl/core/tcw_pkg.sv
// Package for the text console writer: item types, action codes and
// character constants. No dependencies.
`default_nettype none

package tcw_pkg;

  // Action codes carried in the action field of an input item.
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_SPACE     = 8'd32;

  // Colour attribute after reset: white on black.
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } tcw_out_t;

endpackage

`default_nettype wire

### rtl/core/text_console_writer.sv
// Text console writer: a ROWS by COLUMNS text screen held in one cell memory,
// with a cursor, scrolling, clearing and cell read-back. Uses tcw_pkg.
//
//   channel  direction  handshake                   payload
//   in       input      in_valid_i / in_stall_o     in_item_i   (tcw_in_t)
//   out      output     out_valid_o / out_stall_i   out_item_o  (tcw_out_t)
//   cfg      input      cfg_we_i                    cfg_wdata_i (attribute byte)
//
// For a put without scrolling, a read and an unused action, the accept
// cycle writes or reads the cell memory and the done state loads the result
// once the output register is free. Clear and scroll first sweep every cell,
// with one memory write per cycle. After reset a sweep fills the screen
// with blanks before the first item is accepted.
// An item is accepted while an earlier result still waits in the output
// register; its own result is then held until that register frees.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire tcw_pkg::tcw_in_t in_item_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output tcw_pkg::tcw_out_t out_item_o,
  input  wire              cfg_we_i,
  input  wire [7:0]        cfg_wdata_i
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int NW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [15:0]       cells_q [CELLS];
  logic [1:0]        state_q, state_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [7:0]        attr_q;
  logic              init_q;
  logic              scroll_q;
  logic [15:0]       fill_q;
  logic [NW-1:0]     ctr_q;
  logic              wb_vld_q, wb_mem_q;
  logic [AW-1:0]     wb_addr_q;
  logic [15:0]       rdata_q;
  logic              rd_hit_q;
  logic              out_valid_q;
  tcw_pkg::tcw_out_t out_q;

  logic              in_acc;
  logic              last_row, last_col;
  logic              put_we, do_scroll;
  logic [RW-1:0]     put_row;
  logic [CW-1:0]     put_col;
  logic [7:0]        put_ch;
  logic [AW-1:0]     put_addr, rd_addr, mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_we, rd_en;
  logic              sweep_iss, sweep_from_mem, sweep_end;
  logic              rd_in_range;
  logic              out_free;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign last_row = (row_q == RW'(ROWS - 1));
  assign last_col = (col_q == CW'(COLUMNS - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  // Cursor update and the single cell write, if any, of a put.
  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    put_we    = 1'b0;
    put_row   = row_q;
    put_col   = col_q;
    put_ch    = in_item_i.char_code;
    do_scroll = 1'b0;
    if (in_acc) begin
      case (in_item_i.action)
        tcw_pkg::ACT_PUT: begin
          if (in_item_i.char_code == tcw_pkg::CHAR_NEWLINE) begin
            col_d = '0;
            if (last_row) begin
              do_scroll = 1'b1;
            end else begin
              row_d = row_q + RW'(1);
            end
          end else if (in_item_i.char_code == tcw_pkg::CHAR_BACKSPACE) begin
            put_ch = tcw_pkg::CHAR_SPACE;
            if (col_q != '0) begin
              col_d   = col_q - CW'(1);
              put_col = col_q - CW'(1);
              put_we  = 1'b1;
            end else if (row_q != '0) begin
              row_d   = row_q - RW'(1);
              col_d   = CW'(COLUMNS - 1);
              put_row = row_q - RW'(1);
              put_col = CW'(COLUMNS - 1);
              put_we  = 1'b1;
            end
          end else begin
            put_we = 1'b1;
            if (last_col) begin
              col_d = '0;
              if (last_row) begin
                do_scroll = 1'b1;
              end else begin
                row_d = row_q + RW'(1);
              end
            end else begin
              col_d = col_q + CW'(1);
            end
          end
        end
        tcw_pkg::ACT_CLEAR: begin
          row_d = '0;
          col_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign put_addr = AW'(32'(put_row) * COLUMNS + 32'(put_col));

  assign rd_in_range = (32'(in_item_i.read_row) < ROWS) && (32'(in_item_i.read_col) < COLUMNS);

  // The sweep walks destination cells in order. When scrolling, each cell is
  // read one row below and written back in the next cycle; the bottom row and
  // every cell of a clear take the fill word.
  assign sweep_iss      = (state_q == ST_SWEEP) && (ctr_q < NW'(CELLS));
  assign sweep_from_mem = scroll_q && (ctr_q < NW'(CELLS - COLUMNS));
  assign sweep_end      = (state_q == ST_SWEEP) && (ctr_q == NW'(CELLS));

  always_comb begin
    if (state_q == ST_SWEEP) begin
      rd_addr = AW'(32'(ctr_q) + COLUMNS);
      rd_en   = sweep_iss && sweep_from_mem;
    end else begin
      rd_addr = AW'(32'(in_item_i.read_row) * COLUMNS + 32'(in_item_i.read_col));
      rd_en   = in_acc && (in_item_i.action == tcw_pkg::ACT_READ) && rd_in_range;
    end
  end

  assign mem_we    = put_we || wb_vld_q;
  assign mem_waddr = wb_vld_q ? wb_addr_q : put_addr;
  assign mem_wdata = wb_vld_q ? (wb_mem_q ? rdata_q : fill_q) : {attr_q, put_ch};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= cells_q[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (do_scroll || (in_item_i.action == tcw_pkg::ACT_CLEAR)) begin
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_end) begin
          state_d = init_q ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      row_q       <= '0;
      col_q       <= '0;
      attr_q      <= tcw_pkg::ATTR_RESET;
      init_q      <= 1'b1;
      scroll_q    <= 1'b0;
      fill_q      <= {tcw_pkg::ATTR_RESET, tcw_pkg::CHAR_SPACE};
      ctr_q       <= '0;
      wb_vld_q    <= 1'b0;
      wb_mem_q    <= 1'b0;
      rd_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        rd_hit_q <= (in_item_i.action == tcw_pkg::ACT_READ) && rd_in_range;
        scroll_q <= do_scroll;
        fill_q   <= {attr_q, tcw_pkg::CHAR_SPACE};
        ctr_q    <= '0;
      end else if (sweep_iss) begin
        ctr_q <= ctr_q + NW'(1);
      end
      if (sweep_end) begin
        init_q <= 1'b0;
      end
      wb_vld_q <= sweep_iss;
      wb_mem_q <= sweep_from_mem;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (sweep_iss) begin
      wb_addr_q <= ctr_q[AW-1:0];
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q.cell_word  <= rd_hit_q ? rdata_q : 16'd0;
      out_q.cursor_row <= 5'(row_q);
      out_q.cursor_col <= 7'(col_q);
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A sweep write must never meet the write of a newly accepted put.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |-> !wb_vld_q)
    else $error("sweep write still pending when an item was accepted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
    else $error("cursor outside the screen");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (ctr_q <= NW'(CELLS)))
    else $error("sweep counter ran past the screen");

  // A result is never loaded over one that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(out_q))
    else $error("output item overwritten while stalled");

endmodule

`default_nettype wire
